FILE: rtl/hdr_pkg.sv
`timescale 1ns / 1ps

package hdr_pkg;

    // Fixed field widths of the item channels.
    localparam int VAL_W       = 6;
    localparam int OUT_CNT_W   = 16;
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;
    localparam logic [VAL_W-1:0]     MAX_VALUE_RESET = 6'd63;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture the input item and read its counter
        logic update;      // write back the incremented counter
        logic scan_init;   // start a scan at entry zero
        logic scan_read;   // read the entry under the scan index
        logic idx_inc;     // advance the scan index
        logic pend_load;   // hold the current entry as the pending duplicate
        logic emit_pend;   // send the pending duplicate, more to follow
        logic emit_final;  // send the closing item of the report
        logic clear_set;   // forget all counts and the error flag
    } hdr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;    // an input item is offered
        logic last;        // the captured item closes the set
        logic is_dup;      // the entry just read was seen more than once
        logic pend_valid;  // a duplicate waits to be sent
        logic out_free;    // the output register can take an item now
        logic scan_done;   // the scan index sits on the last entry
    } hdr_status_t;

endpackage

FILE: rtl/hdr_in_if.sv
`timescale 1ns / 1ps

interface hdr_in_if;
    import hdr_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic             last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink (input valid, input value, input last_item, output ready);
endinterface

FILE: rtl/hdr_out_if.sv
`timescale 1ns / 1ps

interface hdr_out_if;
    import hdr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VAL_W-1:0]     dup_value;
    logic [OUT_CNT_W-1:0] dup_count;
    logic                 none_found;
    logic                 range_error;
    logic                 run_end;

    modport source (
        output valid, output dup_value, output dup_count, output none_found,
        output range_error, output run_end, input ready
    );
    modport sink (
        input valid, input dup_value, input dup_count, input none_found,
        input range_error, input run_end, output ready
    );
endinterface

FILE: rtl/hdr_datapath.sv
`timescale 1ns / 1ps

module hdr_datapath #(
    parameter int HIST_DEPTH  = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hdr_pkg::VAL_W-1:0]    cfg_wdata,
    input  logic                         in_valid,
    input  logic [hdr_pkg::VAL_W-1:0]    in_value,
    input  logic                         in_last,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [hdr_pkg::VAL_W-1:0]    out_dup_value,
    output logic [hdr_pkg::OUT_CNT_W-1:0] out_dup_count,
    output logic                         out_none_found,
    output logic                         out_range_error,
    output logic                         out_run_end,
    input  hdr_pkg::hdr_cmd_t            cmd,
    output hdr_pkg::hdr_status_t         status
);
    import hdr_pkg::*;

    localparam int AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int EXT_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;
    localparam int CMP_W = VAL_W + 1;

    // Histogram store and its per-entry valid bits.
    logic [COUNT_WIDTH-1:0] hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]  valid_reg;

    logic [VAL_W-1:0]       max_value_reg;
    logic                   overflow_reg;
    logic [VAL_W-1:0]       value_reg;
    logic                   last_reg;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          top_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [AW-1:0]          pend_idx_reg;
    logic [COUNT_WIDTH-1:0] pend_count_reg;
    logic                   pend_valid_reg;

    logic                   out_valid_reg;
    logic [VAL_W-1:0]       out_value_reg;
    logic [OUT_CNT_W-1:0]   out_count_reg;
    logic                   out_none_reg;
    logic                   out_err_reg;
    logic                   out_end_reg;

    logic [AW-1:0]          rd_addr;
    logic                   in_range;
    logic [COUNT_WIDTH-1:0] count_cur;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [AW-1:0]          top_next;
    logic [EXT_W-1:0]       pend_ext;
    logic [OUT_CNT_W-1:0]   pend_count_out;
    logic                   out_free;

    // Read address: the incoming value while loading, the scan index otherwise.
    assign rd_addr = cmd.load_item ? in_value[AW-1:0] : idx_reg;

    // A value is counted only at or below max_value and inside the store.
    assign in_range = (value_reg <= max_value_reg) &&
                      (CMP_W'(value_reg) < CMP_W'(HIST_DEPTH));

    // Saturating increment; an entry not yet written reads as zero.
    assign count_cur = rd_valid_reg ? rd_data_reg : '0;
    assign count_inc = (count_cur == '1) ? count_cur : count_cur + COUNT_WIDTH'(1);

    // The scan stops at the smaller of max_value and the last entry.
    always_comb
    begin
        if (CMP_W'(max_value_reg) > CMP_W'(HIST_DEPTH - 1))
        begin
            top_next = AW'(HIST_DEPTH - 1);
        end
        else
        begin
            top_next = max_value_reg[AW-1:0];
        end
    end

    // Reported count is clipped to the output field.
    assign pend_ext       = EXT_W'(pend_count_reg);
    assign pend_count_out = (pend_ext > EXT_W'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                              : pend_ext[OUT_CNT_W-1:0];

    assign out_free = !out_valid_reg || out_ready;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.update && in_range)
        begin
            hist_mem[value_reg[AW-1:0]] <= count_inc;
        end
        if (cmd.load_item || cmd.scan_read)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // Control state of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            max_value_reg  <= MAX_VALUE_RESET;
            overflow_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_value_reg <= cfg_wdata;
            end
            if (cmd.update)
            begin
                if (in_range)
                begin
                    valid_reg[value_reg[AW-1:0]] <= 1'b1;
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.scan_init)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.clear_set)
            begin
                valid_reg      <= '0;
                overflow_reg   <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.emit_pend || cmd.emit_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            value_reg <= in_value;
            last_reg  <= in_last;
        end
        if (cmd.load_item || cmd.scan_read)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (cmd.scan_init)
        begin
            idx_reg <= '0;
            top_reg <= top_next;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.pend_load)
        begin
            pend_idx_reg   <= idx_reg;
            pend_count_reg <= rd_data_reg;
        end
        if (cmd.emit_pend || (cmd.emit_final && pend_valid_reg))
        begin
            out_value_reg <= VAL_W'(pend_idx_reg);
            out_count_reg <= pend_count_out;
            out_none_reg  <= 1'b0;
            out_err_reg   <= overflow_reg;
            out_end_reg   <= cmd.emit_final;
        end
        else if (cmd.emit_final)
        begin
            out_value_reg <= '0;
            out_count_reg <= '0;
            out_none_reg  <= 1'b1;
            out_err_reg   <= overflow_reg;
            out_end_reg   <= 1'b1;
        end
    end

    // Status to the controller.
    always_comb
    begin
        status.in_valid   = in_valid;
        status.last       = last_reg;
        status.is_dup     = rd_valid_reg && (rd_data_reg > COUNT_WIDTH'(1));
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
        status.scan_done  = (idx_reg == top_reg);
    end

    assign out_valid       = out_valid_reg;
    assign out_dup_value   = out_value_reg;
    assign out_dup_count   = out_count_reg;
    assign out_none_found  = out_none_reg;
    assign out_range_error = out_err_reg;
    assign out_run_end     = out_end_reg;

    // A result is never loaded over one that is still waiting.
    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_pend || cmd.emit_final) |-> out_free)
        else $error("result loaded over a waiting result");

    // Closing the report leaves an empty set behind.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_set |=> (valid_reg == '0) && !overflow_reg && !pend_valid_reg)
        else $error("set not cleared after report");

    // A pending duplicate is only ever overwritten while it is being sent.
    a_pend_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pend_load && pend_valid_reg) |-> cmd.emit_pend)
        else $error("pending duplicate dropped");

    // A none-found item always closes the report.
    a_none_closes: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_none_reg |-> out_end_reg)
        else $error("none-found item does not close the report");

endmodule

FILE: rtl/hdr_ctrl.sv
`timescale 1ns / 1ps

module hdr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hdr_pkg::hdr_status_t status,
    output hdr_pkg::hdr_cmd_t    cmd,
    output logic                 in_ready
);
    import hdr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
                state_next    = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                // A new duplicate pushes the held one out, so wait for room.
                if (!(status.is_dup && status.pend_valid && !status.out_free))
                begin
                    cmd.pend_load = status.is_dup;
                    cmd.emit_pend = status.is_dup && status.pend_valid;
                    if (status.scan_done)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_SCAN_RD;
                    end
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    cmd.clear_set  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

FILE: rtl/histogram_duplicate_report_unit.sv
`timescale 1ns / 1ps

// Histogram duplicate report. Each input item carries one value, which is
// counted in a store of HIST_DEPTH saturating counters; values above
// max_value are not counted and set the range error flag. Each item has its
// counter read from the histogram memory and then written back. The item
// marked last_item starts a report: the store is scanned from zero to
// min(max_value, HIST_DEPTH - 1), each entry read through the single memory
// read port and then checked, with stalls while the output is not taken.
// Duplicates come out in ascending order, the last with run_end set; a set
// without duplicates gives one none-found item. The store and the flag are
// then cleared through the valid bits, and input is taken again.
module histogram_duplicate_report_unit #(
    parameter int HIST_DEPTH  = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [hdr_pkg::VAL_W-1:0] cfg_wdata,
    hdr_in_if.sink                    in_ch,
    hdr_out_if.source                 out_ch
);
    import hdr_pkg::*;

    hdr_cmd_t    cmd;
    hdr_status_t status;
    logic        in_ready;

    hdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    hdr_datapath #(
        .HIST_DEPTH  (HIST_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_ch.valid),
        .in_value        (in_ch.value),
        .in_last         (in_ch.last_item),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_dup_value   (out_ch.dup_value),
        .out_dup_count   (out_ch.dup_count),
        .out_none_found  (out_ch.none_found),
        .out_range_error (out_ch.range_error),
        .out_run_end     (out_ch.run_end),
        .cmd             (cmd),
        .status          (status)
    );

    assign in_ch.ready = in_ready;

endmodule

FILE: verif/histogram_duplicate_report_unit_tb.sv
`timescale 1ns / 1ps

// Keeps a private histogram of the set being loaded and, when the closing
// item arrives, works out the duplicate report the block must send.
class dup_report_checker;

    typedef struct packed {
        logic [hdr_pkg::VAL_W-1:0]     dup_value;
        logic [hdr_pkg::OUT_CNT_W-1:0] dup_count;
        logic                          none_found;
        logic                          range_error;
        logic                          run_end;
    } report_t;

    localparam int HIST_ENTRIES = 64;
    localparam logic [15:0] COUNT_FULL = 16'hFFFF;

    logic [15:0]               counts[HIST_ENTRIES];
    logic                      range_hit;
    logic [hdr_pkg::VAL_W-1:0] max_value;
    report_t                   expected_reports[$];
    int                        errors;

    function new();
        clear_counts();
        max_value = hdr_pkg::MAX_VALUE_RESET;
        errors = 0;
    endfunction

    function void clear_counts();
        foreach (counts[i])
            counts[i] = '0;
        range_hit = 1'b0;
    endfunction

    function void set_max(logic [hdr_pkg::VAL_W-1:0] m);
        max_value = m;
    endfunction

    // Count one accepted value; the closing item also builds the report.
    function void note_value(logic [hdr_pkg::VAL_W-1:0] v, logic last);
        int i;
        int found;
        report_t r;
        if (v > max_value)
            range_hit = 1'b1;
        else if (counts[v] != COUNT_FULL)
            counts[v] = counts[v] + 16'd1;
        if (!last)
            return;
        found = 0;
        for (i = 0; i <= max_value; i++)
        begin
            if (counts[i] > 16'd1)
            begin
                r.dup_value   = i[hdr_pkg::VAL_W-1:0];
                r.dup_count   = counts[i];
                r.none_found  = 1'b0;
                r.range_error = range_hit;
                r.run_end     = 1'b0;
                expected_reports.push_back(r);
                found++;
            end
        end
        if (found == 0)
        begin
            r.dup_value   = '0;
            r.dup_count   = '0;
            r.none_found  = 1'b1;
            r.range_error = range_hit;
            r.run_end     = 1'b1;
            expected_reports.push_back(r);
        end
        else
        begin
            r = expected_reports.pop_back();
            r.run_end = 1'b1;
            expected_reports.push_back(r);
        end
        clear_counts();
    endfunction

    function void flag(string what, report_t want, report_t got);
        errors++;
        if (errors <= 10)
            $display({"%0t: %s: expected value=%0d count=%0d none=%b err=%b end=%b,",
                      " got value=%0d count=%0d none=%b err=%b end=%b"},
                     $time, what, want.dup_value, want.dup_count, want.none_found,
                     want.range_error, want.run_end, got.dup_value, got.dup_count,
                     got.none_found, got.range_error, got.run_end);
    endfunction

    // Compare one result item against the oldest expected report entry.
    function void check_report(report_t got);
        report_t want;
        if (expected_reports.size() == 0)
        begin
            flag("unexpected report item", '0, got);
            return;
        end
        want = expected_reports.pop_front();
        if (got.dup_value !== want.dup_value || got.dup_count !== want.dup_count ||
            got.none_found !== want.none_found || got.range_error !== want.range_error ||
            got.run_end !== want.run_end)
            flag("report item mismatch", want, got);
    endfunction

endclass

module histogram_duplicate_report_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 140;
    localparam int CALM_FROM      = 110;
    localparam int REPEAT_ITEMS   = 5;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [hdr_pkg::VAL_W-1:0] cfg_wdata;

    hdr_in_if  in_ch();
    hdr_out_if out_ch();

    dup_report_checker sb;

    bit quiet;
    bit tx_gap_on;
    bit rx_stall_on;
    int items_sent;
    int idle_cycles;
    int stall_left;

    histogram_duplicate_report_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one item and hold it until the block takes it, then maybe pause.
    task automatic send_item(input logic [hdr_pkg::VAL_W-1:0] v, input logic last);
        in_ch.valid     <= 1'b1;
        in_ch.value     <= v;
        in_ch.last_item <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (tx_gap_on && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Let the whole report come out, then give the block time to clear.
    // The first edge lets the monitor note the closing item before the check.
    task automatic wait_report_done();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max(input logic [hdr_pkg::VAL_W-1:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_max(m);
    endtask

    // One set of random length; values mostly come from a small per-set pool
    // so that duplicates are common, with some in-range and wide-range noise.
    task automatic random_set();
        int n;
        int i;
        int pick;
        logic [hdr_pkg::VAL_W-1:0] pool[3];
        logic [hdr_pkg::VAL_W-1:0] v;
        n = $urandom_range(1, 12);
        foreach (pool[k])
            pool[k] = hdr_pkg::VAL_W'($urandom_range(0, sb.max_value));
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                v = pool[$urandom_range(0, 2)];
            else if (pick < 8)
                v = hdr_pkg::VAL_W'($urandom_range(0, sb.max_value));
            else
                v = hdr_pkg::VAL_W'($urandom_range(0, 63));
            send_item(v, i == n - 1);
            items_sent++;
        end
        wait_report_done();
    endtask

    // Result side: stall in short random bursts while stalls are enabled and not quiet.
    initial
    begin
        out_ch.ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rx_stall_on && !quiet && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Observe both channels at each edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_report('{out_ch.dup_value, out_ch.dup_count, out_ch.none_found,
                                  out_ch.range_error, out_ch.run_end});
            if (in_ch.valid && in_ch.ready)
                sb.note_value(in_ch.value, in_ch.last_item);
        end
    end

    // Give up when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("histogram_duplicate_report_unit_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        sb = new();
        quiet = 1'b0;
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
        items_sent = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last_item <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes at the reset limit: 0 and 63 both repeat.
        send_item(6'd0, 1'b0);
        send_item(6'd63, 1'b0);
        send_item(6'd0, 1'b0);
        send_item(6'd63, 1'b0);
        send_item(6'd63, 1'b0);
        send_item(6'd5, 1'b1);
        wait_report_done();

        // A set of one item, and a set with no repeats.
        send_item(6'd7, 1'b1);
        wait_report_done();
        send_item(6'd1, 1'b0);
        send_item(6'd2, 1'b0);
        send_item(6'd3, 1'b1);
        wait_report_done();

        // Values above the limit, including on the closing item.
        write_max(6'd10);
        send_item(6'd11, 1'b0);
        send_item(6'd10, 1'b0);
        send_item(6'd10, 1'b0);
        send_item(6'd0, 1'b0);
        send_item(6'd11, 1'b1);
        wait_report_done();
        send_item(6'd63, 1'b0);
        send_item(6'd20, 1'b1);
        wait_report_done();

        // Smallest limit: only zero is counted.
        write_max(6'd0);
        send_item(6'd0, 1'b0);
        send_item(6'd0, 1'b0);
        send_item(6'd1, 1'b1);
        wait_report_done();
        send_item(6'd0, 1'b1);
        wait_report_done();

        // One value repeated back to back, with a second duplicate below it.
        write_max(6'd63);
        tx_gap_on = 1'b0;
        send_item(6'd3, 1'b0);
        send_item(6'd3, 1'b0);
        for (i = 0; i < REPEAT_ITEMS; i++)
            send_item(6'd42, 1'b0);
        send_item(6'd42, 1'b1);
        wait_report_done();

        // Random sets with occasional limit changes; the tail runs without idling.
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= CALM_FROM)
                quiet = 1'b1;
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       write_max(6'd0);
                    1:       write_max(6'd63);
                    default: write_max(hdr_pkg::VAL_W'($urandom_range(0, 63)));
                endcase
            end
            tx_gap_on = 1'($urandom_range(0, 1));
            rx_stall_on = 1'($urandom_range(0, 1));
            random_set();
        end

        in_ch.valid <= 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_reports.size() == 0)
            $display("histogram_duplicate_report_unit_tb: clean");
        else
            $display("histogram_duplicate_report_unit_tb: errors");
        $finish;
    end

endmodule
